>>> rtl/i2cbm_pkg.sv
package i2cbm_pkg;

  localparam int unsigned HalfW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned ModeW = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned TdataW = 16;

  localparam logic [HalfW-1:0] WriteHalfReset = 16'd5;
  localparam logic [HalfW-1:0] ReadHalfReset = 16'd50;
  localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WRITE_HALF = 1'b0,
    CFG_READ_HALF  = 1'b1
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_READ  = 3'd4,
    MODE_ACK   = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_STOP_A  = 4'd3,
    PH_STOP_B  = 4'd4,
    PH_ACK_A   = 4'd5,
    PH_ACK_B   = 4'd6,
    PH_WR_LOW  = 4'd7,
    PH_WR_HIGH = 4'd8,
    PH_WR_ACKH = 4'd9,
    PH_WR_ACKL = 4'd10,
    PH_RD_LOW  = 4'd11,
    PH_RD_HIGH = 4'd12
  } phase_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ByteW-1:0] write_data;
    logic             ack_bit;
    logic             sda_level;
  } tick_t;

  typedef struct packed {
    logic [HalfW-1:0] write_half_ticks;
    logic [HalfW-1:0] read_half_ticks;
  } cfg_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_pull_low;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_data;
    logic             ack_seen;
  } result_t;

endpackage

>>> rtl/i2cbm_cfg.sv
module i2cbm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cbm_pkg::HalfW-1:0]    cfg_data_i,
  output i2cbm_pkg::cfg_t                cfg_o
);
  import i2cbm_pkg::*;

  logic [HalfW-1:0] write_half_q;
  logic [HalfW-1:0] read_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_half_q <= WriteHalfReset;
      read_half_q  <= ReadHalfReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WRITE_HALF: write_half_q <= cfg_data_i;
        CFG_READ_HALF:  read_half_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.write_half_ticks = write_half_q;
  assign cfg_o.read_half_ticks  = read_half_q;

endmodule

>>> rtl/i2cbm_core.sv
module i2cbm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cbm_pkg::tick_t    tick_i,
  input  i2cbm_pkg::cfg_t     cfg_i,
  output i2cbm_pkg::result_t  result_o
);
  import i2cbm_pkg::*;

  phase_e             phase_q, phase_d;
  logic [BitCntW-1:0] bit_count_q, bit_count_d;
  logic [HalfW-1:0]   tick_count_q, tick_count_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               scl_q, scl_d;
  logic               pull_q, pull_d;
  logic [ByteW-1:0]   last_read_q, last_read_d;
  logic               last_ack_q, last_ack_d;
  logic               done;
  logic [HalfW-1:0]   raw_len;
  logic [HalfW-1:0]   seg_len;

  always_comb begin
    if (phase_q == PH_RD_LOW || phase_q == PH_RD_HIGH) begin
      raw_len = cfg_i.read_half_ticks;
    end else begin
      raw_len = cfg_i.write_half_ticks;
    end
    seg_len = (raw_len == '0) ? HalfW'(1) : raw_len;
  end

  always_comb begin
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    tick_count_d = tick_count_q;
    shift_d      = shift_q;
    scl_d        = scl_q;
    pull_d       = pull_q;
    last_read_d  = last_read_q;
    last_ack_d   = last_ack_q;
    done         = 1'b0;
    if (phase_q == PH_IDLE) begin
      bit_count_d = '0;
      case (mode_e'(tick_i.mode))
        MODE_START: begin
          phase_d = PH_START_A; scl_d = 1'b1; pull_d = 1'b0; tick_count_d = HalfW'(1);
        end
        MODE_STOP: begin
          phase_d = PH_STOP_A; scl_d = 1'b1; pull_d = 1'b1; tick_count_d = HalfW'(1);
        end
        MODE_WRITE: begin
          shift_d = tick_i.write_data;
          phase_d = PH_WR_LOW; scl_d = 1'b0; pull_d = ~tick_i.write_data[ByteW-1];
          tick_count_d = HalfW'(1);
        end
        MODE_READ: begin
          shift_d = '0;
          phase_d = PH_RD_LOW; scl_d = 1'b0; pull_d = 1'b0; tick_count_d = HalfW'(1);
        end
        MODE_ACK: begin
          phase_d = PH_ACK_A; scl_d = 1'b1; pull_d = ~tick_i.ack_bit;
          tick_count_d = HalfW'(1);
        end
        default: ;
      endcase
    end else if (tick_count_q < seg_len) begin
      tick_count_d = tick_count_q + HalfW'(1);
    end else begin
      tick_count_d = HalfW'(1);
      unique case (phase_q)
        PH_START_A: begin
          phase_d = PH_START_B; scl_d = 1'b1; pull_d = 1'b1;
        end
        PH_START_B: begin
          phase_d = PH_IDLE; scl_d = 1'b0; pull_d = 1'b1; tick_count_d = '0; done = 1'b1;
        end
        PH_STOP_A: begin
          phase_d = PH_STOP_B; scl_d = 1'b1; pull_d = 1'b0;
        end
        PH_STOP_B: begin
          phase_d = PH_IDLE; scl_d = 1'b1; pull_d = 1'b0; tick_count_d = '0; done = 1'b1;
        end
        PH_ACK_A: begin
          phase_d = PH_ACK_B; scl_d = 1'b0;
        end
        PH_ACK_B: begin
          phase_d = PH_IDLE; scl_d = 1'b0; tick_count_d = '0; done = 1'b1;
        end
        PH_WR_LOW: begin
          phase_d = PH_WR_HIGH; scl_d = 1'b1;
        end
        PH_WR_HIGH: begin
          shift_d     = {shift_q[ByteW-2:0], 1'b0};
          bit_count_d = bit_count_q + BitCntW'(1);
          if (bit_count_d >= BitsPerByte) begin
            phase_d = PH_WR_ACKH; scl_d = 1'b1; pull_d = 1'b0;
          end else begin
            phase_d = PH_WR_LOW; scl_d = 1'b0; pull_d = ~shift_q[ByteW-2];
          end
        end
        PH_WR_ACKH: begin
          last_ack_d = tick_i.sda_level;
          phase_d = PH_WR_ACKL; scl_d = 1'b0; pull_d = 1'b0;
        end
        PH_WR_ACKL: begin
          phase_d = PH_IDLE; scl_d = 1'b0; pull_d = 1'b0; tick_count_d = '0; done = 1'b1;
        end
        PH_RD_HIGH: begin
          shift_d     = {shift_q[ByteW-2:0], tick_i.sda_level};
          bit_count_d = bit_count_q + BitCntW'(1);
          phase_d = PH_RD_LOW; scl_d = 1'b0; pull_d = 1'b0;
        end
        PH_RD_LOW: begin
          if (bit_count_q >= BitsPerByte) begin
            last_read_d = shift_q;
            phase_d = PH_IDLE; scl_d = 1'b0; pull_d = 1'b0; tick_count_d = '0; done = 1'b1;
          end else begin
            phase_d = PH_RD_HIGH; scl_d = 1'b1; pull_d = 1'b0;
          end
        end
        default: begin
          phase_d = PH_IDLE; tick_count_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_count_q  <= '0;
      tick_count_q <= '0;
      shift_q      <= '0;
      scl_q        <= 1'b1;
      pull_q       <= 1'b0;
      last_read_q  <= '0;
      last_ack_q   <= 1'b1;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      tick_count_q <= tick_count_d;
      shift_q      <= shift_d;
      scl_q        <= scl_d;
      pull_q       <= pull_d;
      last_read_q  <= last_read_d;
      last_ack_q   <= last_ack_d;
    end
  end

  assign result_o.scl_level    = scl_d;
  assign result_o.sda_pull_low = pull_d;
  assign result_o.busy_res     = (phase_d != PH_IDLE);
  assign result_o.done_res     = done;
  assign result_o.read_data    = last_read_d;
  assign result_o.ack_seen     = last_ack_d;

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> phase_d == PH_IDLE) else $error("done without return to idle");
  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_count_q == '0) else $error("idle with running count");
  a_busy_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> tick_count_q != '0) else $error("busy with zero count");
  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= BitsPerByte) else $error("bit count beyond one byte");
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(tick_count_q)) else $error("state moved without a request");

endmodule

>>> rtl/i2cbm_out_reg.sv
module i2cbm_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  i2cbm_pkg::result_t  result_i,
  input  logic                take_i,
  output logic                space_o,
  output logic                valid_o,
  output i2cbm_pkg::result_t  result_o
);
  import i2cbm_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign space_o = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

>>> rtl/i2c_bit_level_master.sv
// Tick-driven I2C master at bit level. Every request on the slave stream is one bus tick and
// yields exactly one result on the master stream, showing the SCL level, the SDA pull-down and
// the status after that tick. A request is taken in every cycle in which the output register is
// empty or is being read, so one tick a clock is sustained; the sequencer state is updated in
// that same cycle and the result appears in the cycle after. Commands are honoured only while the
// sequencer is idle; segment lengths come from the two half-period registers, which take effect
// immediately on write.
module i2c_bit_level_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cbm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [i2cbm_pkg::HalfW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // mode[2:0], write_data[10:3], ack_bit[11], sda_level[12], zero[15:13]
  input  logic [i2cbm_pkg::TdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // scl_level[0], sda_pull_low[1], busy_res[2], done_res[3], read_data[11:4],
  // ack_seen[12], zero[15:13]
  output logic [i2cbm_pkg::TdataW-1:0]  m_axis_tdata
);
  import i2cbm_pkg::*;

  cfg_t    cfg;
  tick_t   tick;
  result_t step_res;
  result_t out_res;
  logic    space;
  logic    step;

  assign tick.mode       = s_axis_tdata[2:0];
  assign tick.write_data = s_axis_tdata[10:3];
  assign tick.ack_bit    = s_axis_tdata[11];
  assign tick.sda_level  = s_axis_tdata[12];

  assign s_axis_tready = space;
  assign step          = s_axis_tvalid && space;

  i2cbm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  i2cbm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .tick_i   (tick),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

  i2cbm_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (step_res),
    .take_i   (m_axis_tready),
    .space_o  (space),
    .valid_o  (m_axis_tvalid),
    .result_o (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.ack_seen, out_res.read_data, out_res.done_res,
                         out_res.busy_res, out_res.sda_pull_low, out_res.scl_level};

endmodule

>>> verif/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps

module i2c_bit_level_master_tb;
  import i2cbm_pkg::*;

  localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned RunLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseTicks = 150;

  class bus_level_predictor;
    logic [HalfW-1:0] wr_half;
    logic [HalfW-1:0] rd_half;
    phase_e           ph;
    logic [3:0]       nbits;
    logic [HalfW-1:0] tcnt;
    logic [7:0]       shreg;
    logic             scl;
    logic             pull;
    logic [7:0]       rd_byte;
    logic             ack_in;
    result_t          due_levels[$];
    int               n_bad;
    int               n_seen;

    function new();
      wr_half = WriteHalfReset;
      rd_half = ReadHalfReset;
      ph = PH_IDLE;
      nbits = '0;
      tcnt = '0;
      shreg = '0;
      scl = 1'b1;
      pull = 1'b0;
      rd_byte = '0;
      ack_in = 1'b1;
      n_bad = 0;
      n_seen = 0;
    endfunction

    function void set_half(cfg_idx_e idx, logic [HalfW-1:0] val);
      if (idx == CFG_WRITE_HALF) wr_half = val;
      else rd_half = val;
    endfunction

    function logic [HalfW-1:0] seg_ticks();
      logic [HalfW-1:0] v;
      v = (ph == PH_RD_LOW || ph == PH_RD_HIGH) ? rd_half : wr_half;
      return (v == '0) ? 16'd1 : v;
    endfunction

    function void enter_seg(phase_e p, logic s, logic d);
      ph = p;
      scl = s;
      pull = d;
      tcnt = 16'd1;
    endfunction

    function void end_seq(logic s, logic d);
      ph = PH_IDLE;
      scl = s;
      pull = d;
      tcnt = '0;
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function int due_count();
      return due_levels.size();
    endfunction

    function void take_tick(tick_t t);
      logic    fin;
      result_t want;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
        nbits = '0;
        case (t.mode)
          MODE_START: enter_seg(PH_START_A, 1'b1, 1'b0);
          MODE_STOP: enter_seg(PH_STOP_A, 1'b1, 1'b1);
          MODE_WRITE: begin
            shreg = t.write_data;
            enter_seg(PH_WR_LOW, 1'b0, ~shreg[7]);
          end
          MODE_READ: begin
            shreg = '0;
            enter_seg(PH_RD_LOW, 1'b0, 1'b0);
          end
          MODE_ACK: enter_seg(PH_ACK_A, 1'b1, ~t.ack_bit);
          default: ;
        endcase
      end else if (tcnt < seg_ticks()) begin
        tcnt = tcnt + 16'd1;
      end else begin
        case (ph)
          PH_START_A: enter_seg(PH_START_B, 1'b1, 1'b1);
          PH_START_B: begin
            end_seq(1'b0, 1'b1);
            fin = 1'b1;
          end
          PH_STOP_A: enter_seg(PH_STOP_B, 1'b1, 1'b0);
          PH_STOP_B: begin
            end_seq(1'b1, 1'b0);
            fin = 1'b1;
          end
          PH_ACK_A: enter_seg(PH_ACK_B, 1'b0, pull);
          PH_ACK_B: begin
            end_seq(1'b0, pull);
            fin = 1'b1;
          end
          PH_WR_LOW: enter_seg(PH_WR_HIGH, 1'b1, pull);
          PH_WR_HIGH: begin
            shreg = shreg << 1;
            nbits = nbits + 4'd1;
            if (nbits >= BitsPerByte) enter_seg(PH_WR_ACKH, 1'b1, 1'b0);
            else enter_seg(PH_WR_LOW, 1'b0, ~shreg[7]);
          end
          PH_WR_ACKH: begin
            ack_in = t.sda_level;
            enter_seg(PH_WR_ACKL, 1'b0, 1'b0);
          end
          PH_WR_ACKL: begin
            end_seq(1'b0, 1'b0);
            fin = 1'b1;
          end
          PH_RD_HIGH: begin
            shreg = {shreg[6:0], t.sda_level};
            nbits = nbits + 4'd1;
            enter_seg(PH_RD_LOW, 1'b0, 1'b0);
          end
          PH_RD_LOW: begin
            if (nbits >= BitsPerByte) begin
              rd_byte = shreg;
              end_seq(1'b0, 1'b0);
              fin = 1'b1;
            end else begin
              enter_seg(PH_RD_HIGH, 1'b1, 1'b0);
            end
          end
          default: end_seq(scl, pull);
        endcase
      end
      want.scl_level = scl;
      want.sda_pull_low = pull;
      want.busy_res = (ph != PH_IDLE);
      want.done_res = fin;
      want.read_data = rd_byte;
      want.ack_seen = ack_in;
      due_levels.push_back(want);
    endfunction

    function void compare(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        n_bad++;
        if (n_bad <= 10)
          $display("Mismatch on %s at result %0d: expected %0h, got %0h",
                   what, n_seen, want, got);
      end
    endfunction

    function void check_levels(logic [TdataW-1:0] d);
      result_t want;
      n_seen++;
      if (due_levels.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("Result %0d arrived with nothing due: %h", n_seen, d);
        return;
      end
      want = due_levels.pop_front();
      compare("scl_level", 8'(want.scl_level), 8'(d[0]));
      compare("sda_pull_low", 8'(want.sda_pull_low), 8'(d[1]));
      compare("busy_res", 8'(want.busy_res), 8'(d[2]));
      compare("done_res", 8'(want.done_res), 8'(d[3]));
      compare("read_data", want.read_data, d[11:4]);
      compare("ack_seen", 8'(want.ack_seen), 8'(d[12]));
    endfunction

    function void close_out();
      if (due_levels.size() != 0) begin
        n_bad += due_levels.size();
        $display("%0d results never arrived", due_levels.size());
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [HalfW-1:0]    cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [TdataW-1:0]   s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [TdataW-1:0]   m_axis_tdata;

  bus_level_predictor levels = new();
  bit gaps_on = 1'b1;
  bit hold_rx = 1'b0;
  int n_sent = 0;

  i2c_bit_level_master dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic tick_t make_tick(logic [ModeW-1:0] mode, logic [7:0] wdata, logic ackb,
                                      logic sda);
    tick_t t;
    t.mode = mode;
    t.write_data = wdata;
    t.ack_bit = ackb;
    t.sda_level = sda;
    return t;
  endfunction

  // While a sequence runs, an occasional command is offered and must be ignored.
  function automatic tick_t filler_tick();
    logic [ModeW-1:0] m;
    m = MODE_NONE;
    if ($urandom_range(99) < 15) m = ModeW'($urandom_range(7));
    return make_tick(m, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
  endfunction

  function automatic tick_t command_tick();
    logic [ModeW-1:0] m;
    int               r;
    r = $urandom_range(99);
    if (r < 88) m = ModeW'($urandom_range(MODE_ACK, MODE_START));
    else if (r < 92) m = MODE_NONE;
    else if (r < 96) m = MODE_SPARE_LO;
    else m = MODE_SPARE_HI;
    return make_tick(m, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
  endfunction

  task automatic send_tick(tick_t t);
    while (gaps_on && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, t.sda_level, t.ack_bit, t.write_data, t.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    levels.take_tick(t);
    n_sent++;
  endtask

  task automatic run_cmd(tick_t t);
    send_tick(t);
    while (levels.busy()) send_tick(filler_tick());
  endtask

  task automatic drain_ticks();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (levels.due_count() != 0);
  endtask

  task automatic set_half(cfg_idx_e idx, logic [HalfW-1:0] val);
    drain_ticks();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    levels.set_half(idx, val);
  endtask

  task automatic run_phase(logic [HalfW-1:0] wr, logic [HalfW-1:0] rd, bit with_gaps,
                           bit with_hold);
    int stop_at;
    set_half(CFG_WRITE_HALF, wr);
    set_half(CFG_READ_HALF, rd);
    gaps_on = with_gaps;
    stop_at = n_sent + PhaseTicks;
    while (n_sent < stop_at) begin
      run_cmd(command_tick());
      if (with_hold) begin
        hold_rx = 1'b1;
        with_hold = 1'b0;
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 26);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) levels.check_levels(m_axis_tdata);
    end
  end

  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WRITE_HALF;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset lengths, with a stop offered while the start is still running.
    send_tick(make_tick(MODE_START, 8'h00, 1'b0, 1'b1));
    send_tick(make_tick(MODE_STOP, 8'hFF, 1'b1, 1'b0));
    while (levels.busy()) send_tick(make_tick(MODE_NONE, 8'h00, 1'b0, 1'($urandom_range(1))));

    set_half(CFG_WRITE_HALF, 16'd1);
    set_half(CFG_READ_HALF, 16'd1);
    run_cmd(make_tick(MODE_WRITE, 8'hFF, 1'b0, 1'b0));
    run_cmd(make_tick(MODE_WRITE, 8'h00, 1'b1, 1'b1));
    run_cmd(make_tick(MODE_READ, 8'h00, 1'b0, 1'b1));
    run_cmd(make_tick(MODE_ACK, 8'h00, 1'b0, 1'b0));
    run_cmd(make_tick(MODE_ACK, 8'hFF, 1'b1, 1'b1));
    run_cmd(make_tick(MODE_STOP, 8'h5A, 1'b0, 1'b0));
    run_cmd(make_tick(MODE_SPARE_LO, 8'hA5, 1'b1, 1'b0));
    run_cmd(make_tick(MODE_SPARE_HI, 8'hFF, 1'b1, 1'b1));

    // Longest half period, cut short mid-sequence; a zero length counts as one tick.
    set_half(CFG_WRITE_HALF, 16'hFFFF);
    send_tick(make_tick(MODE_START, 8'h00, 1'b0, 1'b1));
    repeat (6) send_tick(filler_tick());
    set_half(CFG_WRITE_HALF, 16'd0);
    while (levels.busy()) send_tick(filler_tick());
    set_half(CFG_READ_HALF, 16'hFFFF);
    send_tick(make_tick(MODE_READ, 8'h00, 1'b0, 1'b0));
    repeat (6) send_tick(filler_tick());
    set_half(CFG_READ_HALF, 16'd1);
    while (levels.busy()) send_tick(filler_tick());

    run_phase(16'd1, 16'd1, 1'b1, 1'b0);
    run_phase(16'd2, 16'd1, 1'b0, 1'b0);
    run_phase(16'd1, 16'd3, 1'b1, 1'b1);
    run_phase(16'd3, 16'd2, 1'b1, 1'b0);
    run_phase(16'd1, 16'd4, 1'b1, 1'b0);

    drain_ticks();
    repeat (4) @(posedge clk_i);
    levels.close_out();
    if (levels.n_bad == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/i2cbm_pkg.sv
rtl/i2cbm_cfg.sv
rtl/i2cbm_core.sv
rtl/i2cbm_out_reg.sv
rtl/i2c_bit_level_master.sv
verif/i2c_bit_level_master_tb.sv
